### hdl/bao_pkg.sv
// Shared types and constants of the button action qualifier.
// Depends on nothing; every other file imports it.
package bao_pkg;

	// Number of pad slots carried by every poll request
	localparam int unsigned PADS_MAX      = 4;
	localparam int unsigned BTN_BITS      = 16;
	localparam int unsigned TRIG_BITS     = 16;
	localparam int unsigned MS_PER_SECOND = 1000;

	// Action modes; the unused code behaves as plain edge mode
	typedef enum logic [1:0] {
		MODE_PLAIN   = 2'd0,
		MODE_REPEAT  = 2'd1,
		MODE_DELAYED = 2'd2
	} mode_t;

	// Result event codes
	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_DOWN = 2'd1,
		EV_UP   = 2'd2
	} event_t;

	// Register indexes of the write port
	typedef enum logic [2:0] {
		REG_ACTION_MODE     = 3'd0,
		REG_REPEAT_RATE     = 3'd1,
		REG_DOWN_DELAY      = 3'd2,
		REG_UP_DELAY        = 3'd3,
		REG_BUTTON_SOURCE   = 3'd4,
		REG_BUTTON_MASK     = 3'd5,
		REG_LEFT_THRESHOLD  = 3'd6,
		REG_RIGHT_THRESHOLD = 3'd7
	} reg_idx_t;

	// Source codes above the single-pad range; higher codes read the key
	localparam logic [2:0] SRC_ANY_PAD = 3'd4;
	localparam logic [2:0] SRC_KEY     = 3'd5;

	// Configuration register set
	typedef struct packed {
		logic [1:0]  action_mode;
		logic [9:0]  repeat_rate;
		logic [15:0] down_delay_ms;
		logic [15:0] up_delay_ms;
		logic [2:0]  button_source;
		logic [15:0] button_mask;
		logic [7:0]  left_threshold;
		logic [7:0]  right_threshold;
	} cfg_t;

endpackage

### hdl/bao_level.sv
// Raw pressed level of the selected source: one pad, any pad or the key.
// Depends on bao_pkg.
module bao_level #(
	parameter int unsigned PAD_COUNT = 4
) (
	input  bao_pkg::cfg_t                                               cfg,
	input  logic                                                        key_down,
	input  logic [bao_pkg::PADS_MAX-1:0]                                pad_connected,
	input  logic [bao_pkg::PADS_MAX-1:0][bao_pkg::BTN_BITS-1:0]         pad_buttons,
	input  logic [bao_pkg::PADS_MAX-1:0][bao_pkg::TRIG_BITS-1:0]        pad_triggers,
	output logic                                                        level
);
	import bao_pkg::*;

	logic [PADS_MAX-1:0] pad_hit;

	// Judge every pad slot independently; slots beyond the pad count stay released
	always_comb begin
		for (int p = 0; p < PADS_MAX; p++) begin
			pad_hit[p] = 1'b0;
			if (p < PAD_COUNT && pad_connected[p]) begin
				pad_hit[p] = (|(pad_buttons[p] & cfg.button_mask))
					|| (cfg.left_threshold != 8'd0
						&& pad_triggers[p][7:0] >= cfg.left_threshold)
					|| (cfg.right_threshold != 8'd0
						&& pad_triggers[p][15:8] >= cfg.right_threshold);
			end
		end
	end

	// Select the source
	always_comb begin
		if (cfg.button_source < SRC_ANY_PAD) begin
			level = pad_hit[cfg.button_source[1:0]];
		end else if (cfg.button_source == SRC_ANY_PAD) begin
			level = |pad_hit;
		end else begin
			level = key_down;
		end
	end

endmodule

### hdl/bao_event.sv
// Event qualifier: plain edges, auto-repeat and delayed press/release, with its state.
// Depends on bao_pkg.
module bao_event #(
	parameter int unsigned TIME_BITS = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bao_pkg::cfg_t         cfg,
	input  logic                  step_en,
	input  logic [TIME_BITS-1:0]  now_ms,
	input  logic                  level,
	output bao_pkg::event_t       ev
);
	import bao_pkg::*;

	localparam logic [TIME_BITS-1:0] ONE_SECOND = TIME_BITS'(MS_PER_SECOND);
	localparam logic [20:0]          PROD_LIMIT = 21'(MS_PER_SECOND);

	logic                 last_sample_q, last_sample_d;
	logic                 qualified_q, qualified_d;
	logic [TIME_BITS-1:0] change_time_q, change_time_d;
	logic [TIME_BITS-1:0] last_event_q, last_event_d;

	logic [TIME_BITS-1:0] since_event;
	logic [TIME_BITS-1:0] since_change;
	logic [9:0]           rate_eff;
	logic [10:0]          since_plus1;
	logic [20:0]          gate_prod;
	logic                 gate_skip;

	// Repeat gate: d below 1000/rate exactly when (d+1)*rate fits in 1000
	always_comb begin
		since_event = now_ms - last_event_q;
		rate_eff    = (cfg.repeat_rate == 10'd0) ? 10'd1 : cfg.repeat_rate;
		since_plus1 = {1'b0, since_event[9:0]} + 11'd1;
		gate_prod   = 21'(since_plus1 * rate_eff);
		gate_skip   = (now_ms < last_event_q)
			|| (since_event < ONE_SECOND && gate_prod <= PROD_LIMIT);
	end

	// Work out the event and the next state
	always_comb begin
		ev            = EV_NONE;
		last_sample_d = last_sample_q;
		qualified_d   = qualified_q;
		change_time_d = change_time_q;
		last_event_d  = last_event_q;
		since_change  = '0;
		unique case (cfg.action_mode)
			MODE_REPEAT: begin
				if (!gate_skip && (level || level != last_sample_q)) begin
					ev            = level ? EV_DOWN : EV_UP;
					last_event_d  = now_ms;
					last_sample_d = level;
				end
			end
			MODE_DELAYED: begin
				if (level != last_sample_q) begin
					change_time_d = now_ms;
				end
				last_sample_d = level;
				since_change  = now_ms - change_time_d;
				if (level != qualified_q) begin
					if (level && since_change >= TIME_BITS'(cfg.down_delay_ms)) begin
						qualified_d = 1'b1;
						ev          = EV_DOWN;
					end else if (!level
						&& since_change >= TIME_BITS'(cfg.up_delay_ms)) begin
						qualified_d = 1'b0;
						ev          = EV_UP;
					end
				end
			end
			default: begin
				if (level != last_sample_q) begin
					ev            = level ? EV_DOWN : EV_UP;
					last_sample_d = level;
				end
			end
		endcase
	end

	// Commit the state when a request moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= 1'b0;
			qualified_q   <= 1'b0;
			change_time_q <= '0;
			last_event_q  <= '0;
		end else if (step_en) begin
			last_sample_q <= last_sample_d;
			qualified_q   <= qualified_d;
			change_time_q <= change_time_d;
			last_event_q  <= last_event_d;
		end
	end

endmodule

### hdl/button_action_qualifier.sv
// Button action qualifier: turns polled key and gamepad state into down/up events.
// Depends on bao_pkg, bao_level and bao_event.
//
// Use: each poll request on the s_ stream carries the time in ms, the key level and
// the state of four pad slots. Every accepted request gives exactly one result on
// the m_ stream: the event code and the raw pressed level of the selected source.
// Registers are written through cfg_we/cfg_index/cfg_data while no request is in
// flight; they take effect for the next request.
// Path: an accepted request passes the input register, then the result register,
// two register stages from s_tdata to m_tdata. Throughput: one request per cycle
// while m_tready is high, set by the single pass of level selection, 11x10
// repeat-gate multiply and time compares between the two registers.
// Stall: while m_tready is low the result holds; a request still enters the input
// register if it is empty, after which s_tready drops until the result is taken.
// Reset: registers return to plain mode, rate one, no delays, key source, masks
// and thresholds off; event state clears to released with times at zero.
module button_action_qualifier #(
	parameter int unsigned TIME_BITS = 48,
	parameter int unsigned PAD_COUNT = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// now_ms, key_down, pad_connected, pad0..3 buttons, pad0..3 triggers, zero fill
	input  logic [((TIME_BITS + 1 + bao_pkg::PADS_MAX
		* (1 + bao_pkg::BTN_BITS + bao_pkg::TRIG_BITS) + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// event_res [1:0], raw_pressed [2], zero fill
	output logic [7:0]            m_tdata,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data
);
	import bao_pkg::*;

	localparam int unsigned KEY_POS  = TIME_BITS;
	localparam int unsigned CONN_LSB = TIME_BITS + 1;
	localparam int unsigned BTN_LSB  = CONN_LSB + PADS_MAX;
	localparam int unsigned TRIG_LSB = BTN_LSB + PADS_MAX * BTN_BITS;

	cfg_t                              cfg_q;
	logic                              valid_s1;
	logic [TIME_BITS-1:0]              now_s1;
	logic                              key_s1;
	logic [PADS_MAX-1:0]               conn_s1;
	logic [PADS_MAX-1:0][BTN_BITS-1:0]  btn_s1;
	logic [PADS_MAX-1:0][TRIG_BITS-1:0] trig_s1;
	logic                              valid_s2;
	event_t                            ev_s2;
	logic                              raw_s2;
	logic                              advance;
	logic                              level;
	event_t                            ev;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.action_mode     <= MODE_PLAIN;
			cfg_q.repeat_rate     <= 10'd1;
			cfg_q.down_delay_ms   <= '0;
			cfg_q.up_delay_ms     <= '0;
			cfg_q.button_source   <= SRC_KEY;
			cfg_q.button_mask     <= '0;
			cfg_q.left_threshold  <= '0;
			cfg_q.right_threshold <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ACTION_MODE:     cfg_q.action_mode     <= cfg_data[1:0];
				REG_REPEAT_RATE:     cfg_q.repeat_rate     <= cfg_data[9:0];
				REG_DOWN_DELAY:      cfg_q.down_delay_ms   <= cfg_data;
				REG_UP_DELAY:        cfg_q.up_delay_ms     <= cfg_data;
				REG_BUTTON_SOURCE:   cfg_q.button_source   <= cfg_data[2:0];
				REG_BUTTON_MASK:     cfg_q.button_mask     <= cfg_data;
				REG_LEFT_THRESHOLD:  cfg_q.left_threshold  <= cfg_data[7:0];
				REG_RIGHT_THRESHOLD: cfg_q.right_threshold <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Handshake: advance the input stage whenever the result register is free
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_s1  <= s_tdata[TIME_BITS-1:0];
			key_s1  <= s_tdata[KEY_POS];
			conn_s1 <= s_tdata[CONN_LSB +: PADS_MAX];
			btn_s1  <= s_tdata[BTN_LSB +: PADS_MAX * BTN_BITS];
			trig_s1 <= s_tdata[TRIG_LSB +: PADS_MAX * TRIG_BITS];
		end
	end

	bao_level #(
		.PAD_COUNT(PAD_COUNT)
	) u_level (
		.cfg          (cfg_q),
		.key_down     (key_s1),
		.pad_connected(conn_s1),
		.pad_buttons  (btn_s1),
		.pad_triggers (trig_s1),
		.level        (level)
	);

	bao_event #(
		.TIME_BITS(TIME_BITS)
	) u_event (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step_en(advance),
		.now_ms (now_s1),
		.level  (level),
		.ev     (ev)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ev_s2  <= ev;
			raw_s2 <= level;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, raw_s2, ev_s2};

endmodule

### dv/tb_button_action_qualifier.sv
// Self-checking testbench for the button action qualifier: poll requests in, one event per request out.
// Depends on bao_pkg and button_action_qualifier; events are predicted in a scoreboard class below.
// Runs a directed pass over the special cases, then randomised phases under several register settings.
module tb_button_action_qualifier;
	import bao_pkg::*;

	localparam int unsigned TIME_W   = 48;
	localparam int unsigned FIELDS_W = TIME_W + 1 + PADS_MAX * (1 + BTN_BITS + TRIG_BITS);
	localparam int unsigned TD_W     = ((FIELDS_W + 7) / 8) * 8;
	localparam int unsigned FILL_W   = TD_W - FIELDS_W;
	localparam int          MAX_SHOWN = 100;

	// Codes outside the package enums
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [2:0] SRC_SPARE_6 = 3'd6;
	localparam logic [2:0] SRC_SPARE_7 = 3'd7;

	// Poll request in s_tdata layout: now_ms in the lowest bits, zero fill on top
	typedef struct packed {
		logic [FILL_W-1:0]                   fill;
		logic [PADS_MAX-1:0][TRIG_BITS-1:0]  triggers;
		logic [PADS_MAX-1:0][BTN_BITS-1:0]   buttons;
		logic [PADS_MAX-1:0]                 connected;
		logic                                key_down;
		logic [TIME_W-1:0]                   now_ms;
	} poll_t;

	typedef struct {
		event_t ev;
		logic   raw;
	} outcome_t;

	// Predicts the event of every accepted poll and checks the results in order
	class qualifier_scoreboard;
		cfg_t              regs;
		bit                last_level;
		bit                qualified;
		logic [TIME_W-1:0] change_ms;
		logic [TIME_W-1:0] last_event_ms;
		logic [9:0]        interval_ms;
		outcome_t          pending_events[$];
		int                errors;

		function new();
			regs = '0;
			regs.repeat_rate = 10'd1;
			regs.button_source = SRC_KEY;
			last_level = 1'b0;
			qualified = 1'b0;
			change_ms = '0;
			last_event_ms = '0;
			interval_ms = 10'(MS_PER_SECOND);
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [15:0] val);
			case (idx)
			REG_ACTION_MODE: regs.action_mode = val[1:0];
			REG_REPEAT_RATE: begin
				// a zero rate counts as one per second
				regs.repeat_rate = val[9:0];
				interval_ms = 10'(MS_PER_SECOND / ((val[9:0] == 10'd0) ? 32'd1 : 32'(val[9:0])));
			end
			REG_DOWN_DELAY: regs.down_delay_ms = val;
			REG_UP_DELAY: regs.up_delay_ms = val;
			REG_BUTTON_SOURCE: regs.button_source = val[2:0];
			REG_BUTTON_MASK: regs.button_mask = val;
			REG_LEFT_THRESHOLD: regs.left_threshold = val[7:0];
			REG_RIGHT_THRESHOLD: regs.right_threshold = val[7:0];
			default: ;
			endcase
		endfunction

		function bit pad_pressed(poll_t p, int unsigned pad);
			if (!p.connected[pad])
				return 1'b0;
			if (regs.button_mask != 0 && (p.buttons[pad] & regs.button_mask) != 0)
				return 1'b1;
			if (regs.left_threshold != 0 && p.triggers[pad][7:0] >= regs.left_threshold)
				return 1'b1;
			if (regs.right_threshold != 0 && p.triggers[pad][15:8] >= regs.right_threshold)
				return 1'b1;
			return 1'b0;
		endfunction

		function bit source_level(poll_t p);
			bit any_pad;
			int unsigned pad;
			any_pad = 1'b0;
			if (regs.button_source < SRC_ANY_PAD)
				return pad_pressed(p, regs.button_source);
			if (regs.button_source == SRC_ANY_PAD) begin
				for (pad = 0; pad < PADS_MAX; pad++)
					any_pad |= pad_pressed(p, pad);
				return any_pad;
			end
			// key source, spare codes included
			return p.key_down;
		endfunction

		function void note_poll(logic [TD_W-1:0] d);
			poll_t p;
			bit level;
			event_t ev;
			logic [TIME_W-1:0] elapsed;
			outcome_t o;
			p = poll_t'(d);
			level = source_level(p);
			ev = EV_NONE;
			if (regs.action_mode == MODE_REPEAT) begin
				// hold off until the interval has passed; a time behind the last event never passes
				if (p.now_ms >= last_event_ms && (p.now_ms - last_event_ms) >= interval_ms
						&& (level || level != last_level)) begin
					if (level)
						ev = EV_DOWN;
					else
						ev = EV_UP;
					last_event_ms = p.now_ms;
					last_level = level;
				end
			end else if (regs.action_mode == MODE_DELAYED) begin
				// restart the hold timer on every change; elapsed time wraps at the time width
				if (level != last_level)
					change_ms = p.now_ms;
				last_level = level;
				elapsed = p.now_ms - change_ms;
				if (level != qualified) begin
					if (level && elapsed >= regs.down_delay_ms) begin
						qualified = 1'b1;
						ev = EV_DOWN;
					end else if (!level && elapsed >= regs.up_delay_ms) begin
						qualified = 1'b0;
						ev = EV_UP;
					end
				end
			end else begin
				// plain edges, unused mode included
				if (level != last_level) begin
					if (level)
						ev = EV_DOWN;
					else
						ev = EV_UP;
					last_level = level;
				end
			end
			o.ev = ev;
			o.raw = level;
			pending_events = {pending_events, o};
		endfunction

		task report(string msg);
			if (errors < MAX_SHOWN)
				$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_event(logic [7:0] d);
			outcome_t o;
			if (pending_events.size() == 0) begin
				report($sformatf("result %h with no request waiting", d));
				return;
			end
			o = pending_events.pop_front();
			if (d[1:0] !== o.ev)
				report($sformatf("event_res %0d, predicted %0d", d[1:0], o.ev));
			if (d[2] !== o.raw)
				report($sformatf("raw_pressed %b, predicted %b", d[2], o.raw));
		endtask

		function int pending();
			return pending_events.size();
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [TD_W-1:0] s_tdata = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [7:0]      m_tdata;
	logic            cfg_we = 1'b0;
	logic [2:0]      cfg_index = '0;
	logic [15:0]     cfg_data = '0;

	qualifier_scoreboard sb;
	poll_t cur;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_left = 0;

	button_action_qualifier #(
		.TIME_BITS(TIME_W),
		.PAD_COUNT(PADS_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Note accepted requests and check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_poll(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_event(m_tdata);
		end
	end

	// Receiver: random stalls, or a long hold-off when one is asked for
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb_button_action_qualifier NOT OK");
		$finish;
	end

	// Offer the current poll after a random gap; return at the edge that takes it
	task automatic send_poll();
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= cur;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Stop sending and hold until every predicted event has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
	endtask

	task automatic program_regs(input logic [1:0] mode, input logic [9:0] rate,
			input logic [15:0] down_ms, input logic [15:0] up_ms, input logic [2:0] src,
			input logic [15:0] mask, input logic [7:0] left_th, input logic [7:0] right_th);
		wait_idle();
		write_reg(REG_ACTION_MODE, 16'(mode));
		write_reg(REG_REPEAT_RATE, 16'(rate));
		write_reg(REG_DOWN_DELAY, down_ms);
		write_reg(REG_UP_DELAY, up_ms);
		write_reg(REG_BUTTON_SOURCE, 16'(src));
		write_reg(REG_BUTTON_MASK, mask);
		write_reg(REG_LEFT_THRESHOLD, 16'(left_th));
		write_reg(REG_RIGHT_THRESHOLD, 16'(right_th));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// New key level and pad state: buttons empty, one bit or random; triggers often idle
	function automatic poll_t reshuffle_pads(poll_t p);
		poll_t q;
		int pick;
		int unsigned pad;
		q = p;
		q.key_down = 1'($urandom_range(1));
		q.connected = 4'($urandom_range(15));
		for (pad = 0; pad < PADS_MAX; pad++) begin
			pick = $urandom_range(2);
			if (pick == 0)
				q.buttons[pad] = '0;
			else if (pick == 1)
				q.buttons[pad] = 16'd1 << $urandom_range(15);
			else
				q.buttons[pad] = 16'($urandom);
			q.triggers[pad][7:0] = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
			q.triggers[pad][15:8] = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
		end
		return q;
	endfunction

	// Mostly steady runs with rising time; now and then a new pad state or a step back in time
	task automatic run_phase(int count, int step_max, int tx_idle, int rx_stall, bit pressure);
		int roll;
		tx_idle_pct = tx_idle;
		rx_stall_pct = rx_stall;
		if ($urandom_range(1))
			cur.now_ms = {16'($urandom_range(65535)), 32'($urandom)};
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			// long receiver hold-off while requests keep coming
			if (pressure && i == 5)
				hold_left = 400;
			if (i == count / 2)
				wait_idle();
			if (roll < 20)
				cur = reshuffle_pads(cur);
			if (roll >= 94)
				cur.now_ms = cur.now_ms - TIME_W'($urandom_range(3000));
			else
				cur.now_ms = cur.now_ms + TIME_W'($urandom_range(step_max));
			send_poll();
		end
	endtask

	initial begin
		sb = new();
		cur = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: plain edges on the key
		cur.now_ms = 48'd5;
		cur.key_down = 1'b1;
		send_poll();
		cur.now_ms = 48'd6;
		send_poll();
		cur.now_ms = 48'd7;
		cur.key_down = 1'b0;
		send_poll();

		// Unused mode on any pad: disconnected pad, button bit, each trigger at and below threshold
		program_regs(MODE_UNUSED, 10'd1, 16'd0, 16'd0, SRC_ANY_PAD, 16'hFFFF, 8'hFF, 8'hFF);
		cur.now_ms = '1;
		cur.connected = '0;
		cur.buttons = '1;
		cur.triggers = '1;
		send_poll();
		cur.connected = 4'b1000;
		cur.buttons = '0;
		cur.triggers = '0;
		cur.buttons[3] = 16'h8000;
		send_poll();
		cur.buttons[3] = 16'h0000;
		cur.triggers[3] = 16'h00FF;
		send_poll();
		cur.triggers[3] = 16'hFF00;
		send_poll();
		cur.triggers[3] = 16'hFEFE;
		send_poll();

		// Repeat at rate zero on a spare key code: gate, repeat, time going back, release
		program_regs(MODE_REPEAT, 10'd0, 16'd0, 16'd0, SRC_SPARE_7, 16'd0, 8'd0, 8'd0);
		cur = '0;
		cur.key_down = 1'b1;
		cur.now_ms = 48'd1000;
		send_poll();
		cur.now_ms = 48'd1500;
		send_poll();
		cur.now_ms = 48'd2000;
		send_poll();
		cur.now_ms = 48'd10;
		send_poll();
		cur.key_down = 1'b0;
		cur.now_ms = 48'd3000;
		send_poll();

		// Rate above a thousand: zero interval, every poll repeats
		program_regs(MODE_REPEAT, 10'd1023, 16'd0, 16'd0, SRC_KEY, 16'd0, 8'd0, 8'd0);
		cur.key_down = 1'b1;
		send_poll();
		send_poll();

		// Delayed on pad 0: longest press hold, immediate release, time going back
		program_regs(MODE_DELAYED, 10'd1, 16'hFFFF, 16'd0, 3'd0, 16'h0001, 8'd0, 8'd0);
		cur = '0;
		cur.connected = 4'b0001;
		cur.buttons[0] = 16'h0001;
		cur.now_ms = 48'd100;
		send_poll();
		cur.now_ms = 48'd65635;
		send_poll();
		cur.buttons[0] = 16'h0000;
		cur.now_ms = 48'd65700;
		send_poll();
		cur.buttons[0] = 16'h0001;
		cur.now_ms = 48'd200000;
		send_poll();
		cur.now_ms = 48'd5;
		send_poll();

		// Randomised phases across settings and idling patterns
		program_regs(MODE_PLAIN, 10'd1, 16'd0, 16'd0, SRC_KEY, 16'd0, 8'd0, 8'd0);
		run_phase(188, 50, 0, 0, 1'b1);
		program_regs(MODE_REPEAT, 10'd10, 16'd0, 16'd0, SRC_ANY_PAD, 16'($urandom),
			8'd128, 8'd200);
		run_phase(188, 300, 81, 0, 1'b0);
		program_regs(MODE_REPEAT, 10'd1000, 16'd0, 16'd0, 3'd1, 16'($urandom), 8'd0,
			8'($urandom_range(1, 255)));
		run_phase(188, 5, 0, 81, 1'b0);
		program_regs(MODE_DELAYED, 10'($urandom_range(1, 1000)), 16'd300, 16'd150, 3'd0,
			16'($urandom), 8'($urandom_range(255)), 8'd0);
		run_phase(188, 200, 32, 32, 1'b0);
		program_regs(MODE_DELAYED, 10'd512, 16'hFFFF, 16'hFFFF, SRC_ANY_PAD, 16'hFFFF,
			8'hFF, 8'hFF);
		run_phase(188, 40000, 0, 0, 1'b1);
		program_regs(MODE_UNUSED, 10'd700, 16'd1234, 16'd4321, SRC_SPARE_6, 16'($urandom),
			8'($urandom_range(255)), 8'($urandom_range(255)));
		run_phase(188, 20, 81, 0, 1'b0);
		program_regs(MODE_REPEAT, 10'd0, 16'($urandom), 16'($urandom), SRC_SPARE_7,
			16'($urandom), 8'($urandom_range(255)), 8'($urandom_range(255)));
		run_phase(188, 700, 0, 81, 1'b0);
		program_regs(MODE_REPEAT, 10'd1023, 16'd0, 16'd0, 3'd2, 16'($urandom), 8'd1, 8'd1);
		run_phase(188, 3, 32, 32, 1'b0);
		program_regs(MODE_DELAYED, 10'd0, 16'd0, 16'd0, 3'd3, 16'hFFFF, 8'd1, 8'd1);
		run_phase(188, 10, 0, 0, 1'b0);
		program_regs(MODE_PLAIN, 10'd1, 16'($urandom), 16'($urandom), SRC_ANY_PAD,
			16'($urandom), 8'hFF, 8'hFF);
		run_phase(188, 10, 0, 81, 1'b1);

		// Drain, then leave room for any stray result
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_button_action_qualifier OK");
		else
			$display("tb_button_action_qualifier NOT OK");
		$finish;
	end

endmodule

### files.f
hdl/bao_pkg.sv
hdl/bao_level.sv
hdl/bao_event.sv
hdl/button_action_qualifier.sv
dv/tb_button_action_qualifier.sv
